// ===== hw/rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants and types for the Life row-step block.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int LR_COLS    = 64;  // cells per row, one lane each
    localparam int LR_WIDTH_W = 7;   // board_width register bits
    localparam int LR_ADDR_W  = 2;   // APB byte address bits
    localparam int LR_DATA_W  = 32;  // APB data bits

    localparam logic [LR_WIDTH_W-1:0] LR_WIDTH_RESET = LR_WIDTH_W'(LR_COLS);
    localparam logic [LR_ADDR_W-1:0]  LR_ADDR_BOARD_WIDTH = '0;

    // output buffer
    localparam int LR_BUF_DEPTH = 4;
    localparam int LR_PTR_W     = $clog2(LR_BUF_DEPTH);
    localparam int LR_CNT_W     = $clog2(LR_BUF_DEPTH + 1);

    // one result row with its end-of-board flag
    typedef struct packed {
        logic               last;
        logic [LR_COLS-1:0] cells;
    } lr_row_t;

    // up to two results written into the output buffer in one cycle
    typedef struct packed {
        logic [1:0] n;      // number of entries written, 0..2
        lr_row_t    first;
        lr_row_t    second;
    } lr_push_t;

endpackage

// ===== hw/rtl/life_automaton_row_step.sv =====
// ----------------------------------------------------------------------------
// life_automaton_row_step
// Conway's Life, one generation, on a board streamed one row per request.
// ----------------------------------------------------------------------------
// A result row is written into the output queue on the accept that completes it.
// One row per cycle while s_tready is high; all 64 columns run in parallel lanes.
// A last row after another row yields two results for the 4-entry output queue;
// s_tready drops when fewer than two entries are free.
// Reset (aresetn low, synchronous): row history and queue clear, width = 64.
// ----------------------------------------------------------------------------
module life_automaton_row_step
    import lr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input rows
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [LR_COLS-1:0]    s_tdata,   // [63:0] row_cells
    input  logic                  s_tlast,   // last_row
    // result rows
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [LR_COLS-1:0]    m_tdata,   // [63:0] next_cells
    output logic                  m_tlast,   // last_out
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LR_ADDR_W-1:0]  paddr,
    input  logic [LR_DATA_W-1:0]  pwdata,
    output logic [LR_DATA_W-1:0]  prdata,
    output logic                  pready
);

    logic [LR_WIDTH_W-1:0] width_reg;
    logic [LR_COLS-1:0]    above_reg, above_next;
    logic [LR_COLS-1:0]    middle_reg, middle_next;
    logic                  mvalid_reg, mvalid_next;

    logic                  accept;
    logic                  room;
    logic [LR_COLS-1:0]    gen_prev;  // row before the incoming one
    logic [LR_COLS-1:0]    gen_tail;  // incoming last row, dead row below
    logic [LR_COLS-1:0]    tail_up;
    lr_push_t              push;
    lr_row_t               out_row;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = LR_DATA_W'(width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= LR_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == LR_ADDR_BOARD_WIDTH)) begin
            width_reg <= pwdata[LR_WIDTH_W-1:0];
        end
    end

    // ---------------- row history ----------------
    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign tail_up  = mvalid_reg ? middle_reg : '0;

    always_comb begin
        above_next  = above_reg;
        middle_next = middle_reg;
        mvalid_next = mvalid_reg;
        if (accept) begin
            if (s_tlast) begin
                above_next  = '0;
                middle_next = '0;
                mvalid_next = 1'b0;
            end else begin
                above_next  = tail_up;
                middle_next = s_tdata;
                mvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg  <= '0;
            middle_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // ---------------- generation units ----------------
    lr_gen u_gen_prev (
        .up_row    (above_reg),
        .mid_row   (middle_reg),
        .down_row  (s_tdata),
        .cfg_width (width_reg),
        .next_row  (gen_prev)
    );

    lr_gen u_gen_tail (
        .up_row    (tail_up),
        .mid_row   (s_tdata),
        .down_row  ('0),
        .cfg_width (width_reg),
        .next_row  (gen_tail)
    );

    // first slot: previous row if there is one, else the tail of a one-row board
    always_comb begin
        push.n = 2'd0;
        if (accept) begin
            push.n = 2'(mvalid_reg) + 2'(s_tlast);
        end
        push.first.cells  = mvalid_reg ? gen_prev : gen_tail;
        push.first.last   = !mvalid_reg;
        push.second.cells = gen_tail;
        push.second.last  = 1'b1;
    end

    // ---------------- output queue ----------------
    lr_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row)
    );

    assign m_tdata = out_row.cells;
    assign m_tlast = out_row.last;

endmodule

// ===== hw/rtl/lr_lane.sv =====
// ----------------------------------------------------------------------------
// lr_lane
// One cell of the Life rule: neighbour count and survive/birth decision.
// ----------------------------------------------------------------------------
module lr_lane
    import lr_pkg::*;
(
    input  logic [2:0] up,    // columns j-1, j, j+1 of the row above
    input  logic [2:0] mid,   // same columns of the current row
    input  logic [2:0] down,  // same columns of the row below
    output logic       alive
);

    logic [3:0] ncount;

    assign ncount = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
                  + 4'(mid[0]) + 4'(mid[2])
                  + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

    assign alive = (ncount == 4'd3) || (mid[1] && (ncount == 4'd2));

endmodule

// ===== hw/rtl/lr_gen.sv =====
// ----------------------------------------------------------------------------
// lr_gen
// One generation of a row: column mask, one lane per column, merged result.
// ----------------------------------------------------------------------------
module lr_gen
    import lr_pkg::*;
(
    input  logic [LR_COLS-1:0]    up_row,
    input  logic [LR_COLS-1:0]    mid_row,
    input  logic [LR_COLS-1:0]    down_row,
    input  logic [LR_WIDTH_W-1:0] cfg_width,
    output logic [LR_COLS-1:0]    next_row
);

    logic [LR_COLS-1:0] col_mask;
    logic [LR_COLS-1:0] lane_alive;
    logic [LR_COLS+1:0] up_pad;
    logic [LR_COLS+1:0] mid_pad;
    logic [LR_COLS+1:0] down_pad;

    // dead border on both sides
    assign up_pad   = {1'b0, up_row   & col_mask, 1'b0};
    assign mid_pad  = {1'b0, mid_row  & col_mask, 1'b0};
    assign down_pad = {1'b0, down_row & col_mask, 1'b0};

    for (genvar j = 0; j < LR_COLS; j++) begin : g_lane
        // widths above the row size keep every column
        assign col_mask[j] = (cfg_width > LR_WIDTH_W'(j));

        lr_lane u_lane (
            .up    (up_pad[j+2:j]),
            .mid   (mid_pad[j+2:j]),
            .down  (down_pad[j+2:j]),
            .alive (lane_alive[j])
        );
    end

    assign next_row = lane_alive & col_mask;

endmodule

// ===== hw/rtl/lr_obuf.sv =====
// ----------------------------------------------------------------------------
// lr_obuf
// Small result queue: up to two rows in a cycle, one out a cycle on out_ready.
// ----------------------------------------------------------------------------
module lr_obuf
    import lr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lr_push_t           push,
    output logic               room,     // space for two more rows
    output logic               out_valid,
    input  logic               out_ready,
    output lr_row_t            out_row
);

    lr_row_t               data_reg [LR_BUF_DEPTH];
    logic [LR_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [LR_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LR_CNT_W-1:0]   count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign out_row   = data_reg[rd_ptr_reg];
    assign room      = (count_reg <= LR_CNT_W'(LR_BUF_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + LR_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + LR_PTR_W'(pop);
        count_next  = count_reg + LR_CNT_W'(push.n) - LR_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            data_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            data_reg[wr_ptr_reg + LR_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== hw/rtl/lr_chk.sv =====
// ----------------------------------------------------------------------------
// lr_chk
// Port-level checks for the Life row-step block, bound to the top level.
// ----------------------------------------------------------------------------
module lr_chk
    import lr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [LR_COLS-1:0]    m_tdata,
    input logic                  m_tlast,
    input logic [LR_DATA_W-1:0]  prdata
);

    // stalled result holds
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // after reset: queue empty, input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("queue not empty after reset");

    // columns beyond the board width are dead
    a_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (prdata[LR_WIDTH_W-1:0] < LR_WIDTH_W'(LR_COLS))
        |-> ((m_tdata >> prdata[LR_WIDTH_W-1:0]) == '0))
        else $error("live cell beyond board width");

endmodule

bind life_automaton_row_step lr_chk u_lr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .prdata   (prdata)
);
